/* rtl/core/vehicle_identity_motion_tracker_unit_macros.svh */
// Assertion macros for the vehicle identity and motion tracker.
`ifndef VEHICLE_IDENTITY_MOTION_TRACKER_UNIT_MACROS_SVH
`define VEHICLE_IDENTITY_MOTION_TRACKER_UNIT_MACROS_SVH

// Check cons in the same cycle as ante.
`define VIMT_ASSERT_SAME(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define VIMT_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/vimt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vimt_pkg;

    typedef enum logic [2:0] {
        TR_NONE        = 3'd0,
        TR_RAW         = 3'd1,
        TR_ANCHORED    = 3'd2,
        TR_REACQUIRED  = 3'd3,
        TR_CHANGED     = 3'd4,
        TR_EXITED      = 3'd5,
        TR_INVALIDATED = 3'd6
    } trans_t;

    localparam logic [31:0] US_PER_SECOND = 32'd1000000;
    localparam logic [47:0] ACC_POS_MAX   = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] ACC_NEG_MAG   = 48'h8000_0000_0000;

    typedef struct packed {
        logic        start;
        logic        drop;
        logic [31:0] velocity_x;
        logic [31:0] velocity_y;
        logic [31:0] velocity_z;
        logic [63:0] time_us;
    } motion_cmd_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [32:0] speed;
        logic        accel_valid;
        logic [47:0] acceleration;
        logic [31:0] interval_us;
    } motion_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/vimt_obs_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface vimt_obs_if;
    logic        valid;
    logic        ready;
    logic        raw_event_seen;
    logic        loading;
    logic        identity_readable;
    logic        identity_fresh;
    logic [63:0] vehicle_address;
    logic [31:0] vehicle_form_id;
    logic        velocity_readable;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] velocity_z;
    logic [63:0] time_us;

    modport source (
        output valid, raw_event_seen, loading, identity_readable, identity_fresh,
               vehicle_address, vehicle_form_id, velocity_readable,
               velocity_x, velocity_y, velocity_z, time_us,
        input  ready
    );

    modport sink (
        input  valid, raw_event_seen, loading, identity_readable, identity_fresh,
               vehicle_address, vehicle_form_id, velocity_readable,
               velocity_x, velocity_y, velocity_z, time_us,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/vimt_res_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface vimt_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  transition;
    logic [31:0] epoch;
    logic        authority_active;
    logic        speed_valid;
    logic [32:0] speed;
    logic        accel_valid;
    logic signed [47:0] acceleration;
    logic [31:0] interval_us;

    modport source (
        output valid, transition, epoch, authority_active, speed_valid, speed,
               accel_valid, acceleration, interval_us,
        input  ready
    );

    modport sink (
        input  valid, transition, epoch, authority_active, speed_valid, speed,
               accel_valid, acceleration, interval_us,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/vimt_motion.sv */
`timescale 1ns / 1ps
`default_nettype none

module vimt_motion (
    input  wire                    clk,
    input  wire                    rst_n,
    input  vimt_pkg::motion_cmd_t  cmd,
    output vimt_pkg::motion_rsp_t  rsp
);
    import vimt_pkg::*;

    localparam int SQUARE_STEPS = 4;
    localparam int ROOT_STEPS   = 32;
    localparam int DIV_STEPS    = 52;
    localparam int CNT_W        = $clog2(DIV_STEPS);

    typedef enum logic [6:0] {
        M_IDLE   = 7'b0000001,
        M_SQUARE = 7'b0000010,
        M_ROOT   = 7'b0000100,
        M_DIFF   = 7'b0001000,
        M_SCALE  = 7'b0010000,
        M_DIVIDE = 7'b0100000,
        M_FINISH = 7'b1000000
    } mstate_t;

    mstate_t           state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              prior_valid_reg, prior_valid_next;
    logic [63:0]       prior_time_reg, prior_time_next;
    logic [31:0]       prior_speed_reg, prior_speed_next;
    logic              has_prior_reg, has_prior_next;

    logic [31:0]       m0_reg, m0_next;
    logic [31:0]       m1_reg, m1_next;
    logic [31:0]       m2_reg, m2_next;
    logic [63:0]       prod_reg, prod_next;
    logic [63:0]       work_reg, work_next;
    logic [63:0]       rem_reg, rem_next;
    logic [51:0]       q_reg, q_next;
    logic [31:0]       spd_reg, spd_next;
    logic [31:0]       diff_reg, diff_next;
    logic              neg_reg, neg_next;
    logic [63:0]       now_reg, now_next;
    logic [63:0]       delta_reg, delta_next;

    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_out;
    logic [64:0]       opa, opb;
    logic [65:0]       sub_full;
    logic              ge;
    logic [31:0]       mag_x, mag_y, mag_z;
    logic [47:0]       mag_sat;
    logic [47:0]       acc_sat;

    assign mag_x = cmd.velocity_x[31] ? (~cmd.velocity_x + 32'd1) : cmd.velocity_x;
    assign mag_y = cmd.velocity_y[31] ? (~cmd.velocity_y + 32'd1) : cmd.velocity_y;
    assign mag_z = cmd.velocity_z[31] ? (~cmd.velocity_z + 32'd1) : cmd.velocity_z;

    assign mul_out  = 64'(mul_a) * 64'(mul_b);
    assign sub_full = {1'b0, opa} - {1'b0, opb};
    assign ge       = ~sub_full[65];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        opa   = '0;
        opb   = '0;
        case (state_reg)
            M_SQUARE:
            begin
                mul_a = m0_reg;
                mul_b = m0_reg;
            end
            M_SCALE:
            begin
                mul_a = diff_reg;
                mul_b = US_PER_SECOND;
            end
            M_ROOT:
            begin
                opa = {30'd0, rem_reg[32:0], work_reg[63:62]};
                opb = {31'd0, q_reg[31:0], 2'b01};
            end
            M_DIFF:
            begin
                opa = {33'd0, q_reg[31:0]};
                opb = {33'd0, prior_speed_reg};
            end
            M_DIVIDE:
            begin
                opa = {rem_reg, work_reg[63]};
                opb = {1'b0, delta_reg};
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        prior_valid_next = prior_valid_reg;
        prior_time_next  = prior_time_reg;
        prior_speed_next = prior_speed_reg;
        has_prior_next   = has_prior_reg;
        m0_next          = m0_reg;
        m1_next          = m1_reg;
        m2_next          = m2_reg;
        prod_next        = prod_reg;
        work_next        = work_reg;
        rem_next         = rem_reg;
        q_next           = q_reg;
        spd_next         = spd_reg;
        diff_next        = diff_reg;
        neg_next         = neg_reg;
        now_next         = now_reg;
        delta_next       = delta_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (cmd.drop)
                begin
                    prior_valid_next = 1'b0;
                    prior_time_next  = '0;
                    prior_speed_next = '0;
                end
                if (cmd.start)
                begin
                    m0_next        = mag_x;
                    m1_next        = mag_y;
                    m2_next        = mag_z;
                    now_next       = cmd.time_us;
                    has_prior_next = !cmd.drop && prior_valid_reg &&
                                     (cmd.time_us > prior_time_reg);
                    delta_next     = cmd.time_us - prior_time_reg;
                    prod_next      = '0;
                    work_next      = '0;
                    cnt_next       = '0;
                    state_next     = M_SQUARE;
                end
            end
            M_SQUARE:
            begin
                prod_next = mul_out;
                work_next = work_reg + prod_reg;
                m0_next   = m1_reg;
                m1_next   = m2_reg;
                m2_next   = '0;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SQUARE_STEPS - 1))
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    q_next     = '0;
                    state_next = M_ROOT;
                end
            end
            M_ROOT:
            begin
                if (ge)
                begin
                    rem_next = sub_full[63:0];
                    q_next   = {q_reg[50:0], 1'b1};
                end
                else
                begin
                    rem_next = opa[63:0];
                    q_next   = {q_reg[50:0], 1'b0};
                end
                work_next = {work_reg[61:0], 2'b00};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                begin
                    state_next = M_DIFF;
                end
            end
            M_DIFF:
            begin
                spd_next   = q_reg[31:0];
                neg_next   = !ge;
                diff_next  = ge ? sub_full[31:0] : (~sub_full[31:0] + 32'd1);
                state_next = has_prior_reg ? M_SCALE : M_FINISH;
            end
            M_SCALE:
            begin
                work_next  = {mul_out[51:0], 12'd0};
                rem_next   = '0;
                q_next     = '0;
                cnt_next   = '0;
                state_next = M_DIVIDE;
            end
            M_DIVIDE:
            begin
                if (ge)
                begin
                    rem_next = sub_full[63:0];
                    q_next   = {q_reg[50:0], 1'b1};
                end
                else
                begin
                    rem_next = opa[63:0];
                    q_next   = {q_reg[50:0], 1'b0};
                end
                work_next = {work_reg[62:0], 1'b0};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = M_FINISH;
                end
            end
            M_FINISH:
            begin
                prior_valid_next = 1'b1;
                prior_time_next  = now_reg;
                prior_speed_next = spd_reg;
                state_next       = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    // saturate the quotient and apply the sign of the speed change
    always_comb
    begin
        if (neg_reg)
        begin
            mag_sat = (q_reg > {4'd0, ACC_NEG_MAG}) ? ACC_NEG_MAG : q_reg[47:0];
            acc_sat = ~mag_sat + 48'd1;
        end
        else
        begin
            mag_sat = q_reg[47:0];
            acc_sat = (q_reg > {4'd0, ACC_POS_MAX}) ? ACC_POS_MAX : q_reg[47:0];
        end
    end

    assign rsp.busy         = (state_reg != M_IDLE);
    assign rsp.done         = (state_reg == M_FINISH);
    assign rsp.speed        = {1'b0, spd_reg};
    assign rsp.accel_valid  = has_prior_reg;
    assign rsp.acceleration = has_prior_reg ? acc_sat : '0;
    assign rsp.interval_us  = !has_prior_reg ? '0 :
                              (|delta_reg[63:32]) ? 32'hFFFF_FFFF : delta_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= M_IDLE;
            cnt_reg         <= '0;
            prior_valid_reg <= 1'b0;
            prior_time_reg  <= '0;
            prior_speed_reg <= '0;
            has_prior_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            prior_valid_reg <= prior_valid_next;
            prior_time_reg  <= prior_time_next;
            prior_speed_reg <= prior_speed_next;
            has_prior_reg   <= has_prior_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m0_reg    <= m0_next;
        m1_reg    <= m1_next;
        m2_reg    <= m2_next;
        prod_reg  <= prod_next;
        work_reg  <= work_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        spd_reg   <= spd_next;
        diff_reg  <= diff_next;
        neg_reg   <= neg_next;
        now_reg   <= now_next;
        delta_reg <= delta_next;
    end

endmodule

`default_nettype wire

/* rtl/core/vehicle_identity_motion_tracker_unit.sv */
// Vehicle identity and motion tracker.
// obs carries one observation per transaction (valid/ready); res returns exactly one
// result per observation, in order, through an output register.
// obs.ready is high only while no observation is in work; a new observation may be
// taken while the previous result still waits in the output register.
// Observations that produce no speed (loading, no anchored identity, velocity
// unreadable) skip the motion unit and go from ST_OUT into the output register.
// Speed without acceleration: squaring on the shared multiplier, 32 restoring
// square-root steps on the shared subtractor, then sign and finish.
// Speed with acceleration adds one scaling multiply by 1000000, then 52 quotient
// bits, one per cycle through the same subtractor.
// No new observation is taken until the previous one reaches the output register.
// When res.ready is low the result holds; the next result waits in its own
// staging register and obs.ready stays low until the output register frees.
// Reset clears the anchored identity, the epoch counter, the fresh-read flag and
// the speed history, and empties both channels.
`timescale 1ns / 1ps
`default_nettype none
`include "vehicle_identity_motion_tracker_unit_macros.svh"

module vehicle_identity_motion_tracker_unit (
    input  wire         clk,
    input  wire         rst_n,
    vimt_obs_if.sink    obs,
    vimt_res_if.source  res
);
    import vimt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t        state_reg, state_next;
    logic          active_reg, active_next;
    logic          need_fresh_reg, need_fresh_next;
    logic [63:0]   held_addr_reg, held_addr_next;
    logic [31:0]   held_form_reg, held_form_next;
    logic [31:0]   epoch_reg, epoch_next;
    logic          out_valid_reg, out_valid_next;

    trans_t        pend_tr_reg;
    logic [31:0]   pend_epoch_reg;
    logic          pend_active_reg;
    logic          pend_speed_valid_reg;
    logic [32:0]   pend_speed_reg;
    logic          pend_accel_valid_reg;
    logic [47:0]   pend_accel_reg;
    logic [31:0]   pend_interval_reg;

    trans_t        out_tr_reg;
    logic [31:0]   out_epoch_reg;
    logic          out_active_reg;
    logic          out_speed_valid_reg;
    logic [32:0]   out_speed_reg;
    logic          out_accel_valid_reg;
    logic [47:0]   out_accel_reg;
    logic [31:0]   out_interval_reg;

    trans_t        tr;
    logic          accept;
    logic          usable;
    logic          exiting;
    logic          load_out;
    motion_cmd_t   mcmd;
    motion_rsp_t   mrsp;

    assign obs.ready = (state_reg == ST_IDLE);
    assign accept    = obs.valid && obs.ready;
    assign load_out  = (state_reg == ST_OUT) && (!out_valid_reg || res.ready);

    assign usable  = obs.identity_readable && (obs.vehicle_address != '0) &&
                     (obs.vehicle_form_id != '0) && (!need_fresh_reg || obs.identity_fresh);
    assign exiting = obs.identity_readable && obs.identity_fresh &&
                     (obs.vehicle_address == '0) && (obs.vehicle_form_id == '0);

    always_comb
    begin
        active_next     = active_reg;
        need_fresh_next = need_fresh_reg;
        held_addr_next  = held_addr_reg;
        held_form_next  = held_form_reg;
        epoch_next      = epoch_reg;
        tr              = obs.raw_event_seen ? TR_RAW : TR_NONE;
        mcmd.start      = 1'b0;
        mcmd.drop       = 1'b0;
        mcmd.velocity_x = obs.velocity_x;
        mcmd.velocity_y = obs.velocity_y;
        mcmd.velocity_z = obs.velocity_z;
        mcmd.time_us    = obs.time_us;
        if (obs.loading)
        begin
            tr              = active_reg ? TR_INVALIDATED : TR_NONE;
            active_next     = 1'b0;
            held_addr_next  = '0;
            held_form_next  = '0;
            need_fresh_next = 1'b1;
            mcmd.drop       = 1'b1;
        end
        else
        begin
            if (usable)
            begin
                if (!active_reg)
                begin
                    active_next     = 1'b1;
                    held_addr_next  = obs.vehicle_address;
                    held_form_next  = obs.vehicle_form_id;
                    epoch_next      = epoch_reg + 32'd1;
                    tr              = need_fresh_reg ? TR_REACQUIRED : TR_ANCHORED;
                    need_fresh_next = 1'b0;
                    mcmd.drop       = 1'b1;
                end
                else if ((held_addr_reg != obs.vehicle_address) ||
                         (held_form_reg != obs.vehicle_form_id))
                begin
                    held_addr_next = obs.vehicle_address;
                    held_form_next = obs.vehicle_form_id;
                    epoch_next     = epoch_reg + 32'd1;
                    tr             = TR_CHANGED;
                    mcmd.drop      = 1'b1;
                end
            end
            else if (exiting)
            begin
                if (active_reg)
                begin
                    tr = TR_EXITED;
                end
                active_next    = 1'b0;
                held_addr_next = '0;
                held_form_next = '0;
                mcmd.drop      = 1'b1;
            end

            if (obs.velocity_readable)
            begin
                if (active_next)
                begin
                    mcmd.start = 1'b1;
                end
                else
                begin
                    mcmd.drop = 1'b1;
                end
            end
        end
        // only a real transaction reaches the motion unit
        mcmd.start = mcmd.start && accept;
        mcmd.drop  = mcmd.drop && accept;
    end

    vimt_motion u_motion (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mcmd),
        .rsp   (mrsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = mcmd.start ? ST_BUSY : ST_OUT;
                end
            end
            ST_BUSY:
            begin
                if (mrsp.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= 1'b0;
            need_fresh_reg <= 1'b0;
            held_addr_reg  <= '0;
            held_form_reg  <= '0;
            epoch_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                active_reg     <= active_next;
                need_fresh_reg <= need_fresh_next;
                held_addr_reg  <= held_addr_next;
                held_form_reg  <= held_form_next;
                epoch_reg      <= epoch_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_tr_reg          <= tr;
            pend_epoch_reg       <= epoch_next;
            pend_active_reg      <= active_next;
            pend_speed_valid_reg <= 1'b0;
            pend_speed_reg       <= '0;
            pend_accel_valid_reg <= 1'b0;
            pend_accel_reg       <= '0;
            pend_interval_reg    <= '0;
        end
        else if ((state_reg == ST_BUSY) && mrsp.done)
        begin
            pend_speed_valid_reg <= 1'b1;
            pend_speed_reg       <= mrsp.speed;
            pend_accel_valid_reg <= mrsp.accel_valid;
            pend_accel_reg       <= mrsp.acceleration;
            pend_interval_reg    <= mrsp.interval_us;
        end
        if (load_out)
        begin
            out_tr_reg          <= pend_tr_reg;
            out_epoch_reg       <= pend_epoch_reg;
            out_active_reg      <= pend_active_reg;
            out_speed_valid_reg <= pend_speed_valid_reg;
            out_speed_reg       <= pend_speed_reg;
            out_accel_valid_reg <= pend_accel_valid_reg;
            out_accel_reg       <= pend_accel_reg;
            out_interval_reg    <= pend_interval_reg;
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.transition       = out_tr_reg;
    assign res.epoch            = out_epoch_reg;
    assign res.authority_active = out_active_reg;
    assign res.speed_valid      = out_speed_valid_reg;
    assign res.speed            = out_speed_reg;
    assign res.accel_valid      = out_accel_valid_reg;
    assign res.acceleration     = out_accel_reg;
    assign res.interval_us      = out_interval_reg;

    `VIMT_ASSERT_SAME(a_ready_unit_idle, obs.ready, !mrsp.busy, "observation taken while unit busy")
    `VIMT_ASSERT_SAME(a_done_when_busy, mrsp.done, state_reg == ST_BUSY, "unit finished outside busy")
    `VIMT_ASSERT_SAME(a_accel_needs_speed, res.valid && res.accel_valid, res.speed_valid && res.authority_active, "acceleration without speed")
    `VIMT_ASSERT_NEXT(a_epoch_step, accept, (epoch_reg == $past(epoch_reg)) || (epoch_reg == $past(epoch_reg) + 32'd1), "epoch moved by more than one")

endmodule

`default_nettype wire
